FILE: src/nearest_segment_ray_hit_top_macros.svh
// Assertion macros for the nearest segment ray hit block.
`ifndef NEAREST_SEGMENT_RAY_HIT_TOP_MACROS_SVH
`define NEAREST_SEGMENT_RAY_HIT_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NSRH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nsrh: implication check failed");

// Next-cycle implication, checked outside reset.
`define NSRH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nsrh: next-cycle check failed");

`endif

FILE: src/nsrh_pkg.sv
// Shared types and constants for the nearest segment ray hit block.
`timescale 1ns / 1ps
`default_nettype none
package nsrh_pkg;

  localparam int MaxSegments = 64;
  localparam int IdxW        = 6;
  localparam int CntW        = 7;
  localparam int CoordW      = 32;
  localparam int DiffW       = CoordW + 1;
  localparam int MulW        = 35;
  localparam int MulPW       = 2 * MulW;
  localparam int CrossW      = 68;
  localparam int NumSplit    = 34;
  localparam int ProdW       = 104;
  localparam int RemW        = CrossW + 1;
  localparam int DivSteps    = ProdW;
  localparam int DivCntW     = 7;
  localparam int SegW        = 4 * CoordW;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CAST   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [4:0] {
    DP_NOP, DP_CLEAR, DP_LATCH, DP_APPEND, DP_RAYINIT, DP_READ, DP_LOAD,
    DP_DEN0, DP_DEN1, DP_NUM0, DP_NUM1, DP_PX0, DP_PX1, DP_PY0, DP_PY1,
    DP_DIVLD, DP_DIVSTEP, DP_FIXQ, DP_SETX, DP_SETY, DP_CHECK,
    DP_DIST0, DP_DIST1, DP_UPDATE, DP_NEXT, DP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_APPEND, ST_RAYINIT, ST_READ, ST_LOAD, ST_DEN0, ST_DEN1,
    ST_NUM0, ST_NUM1, ST_PX0, ST_PX1, ST_DLDX, ST_DIVX, ST_FIXX, ST_SETX,
    ST_PY0, ST_PY1, ST_DLDY, ST_DIVY, ST_FIXY, ST_SETY, ST_CHECK,
    ST_DIST0, ST_DIST1, ST_UPDATE, ST_NEXT, ST_EMIT
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic store_empty;
    logic den_zero;
    logic div_last;
    logic hit_ok;
    logic closer;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: src/nearest_segment_ray_hit_top.sv
// Top level of the nearest segment ray hit block.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_segment_ray_hit_top_macros.svh"
// Stores up to 64 segments (signed Q16.16 endpoints) and answers ray casts
// with the nearest hit. One item is worked at a time. A clear gives no
// result; an append gives one once the output register is free. A cast
// reads each stored segment in turn and skips it when the lines are
// parallel; otherwise it runs two 104-step restoring divisions (one
// quotient bit a cycle) for the hit point, then the range test. The
// finished result waits in an output register.
module nearest_segment_ray_hit_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         opcode_i,
  input  wire logic signed [31:0] start_x_i,
  input  wire logic signed [31:0] start_y_i,
  input  wire logic signed [31:0] end_x_i,
  input  wire logic signed [31:0] end_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    hit_found_o,
  output logic signed [31:0]      hit_x_o,
  output logic signed [31:0]      hit_y_o,
  output logic [5:0]              hit_index_o,
  output logic                    store_full_o
);
  import nsrh_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  nsrh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nsrh_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .hit_found_o  (hit_found_o),
    .hit_x_o      (hit_x_o),
    .hit_y_o      (hit_y_o),
    .hit_index_o  (hit_index_o),
    .store_full_o (store_full_o)
  );

  `NSRH_ASSERT_NEXT(a_append_busy, in_valid_i && in_ready_o && (opcode_i == OP_APPEND), !in_ready_o)
  `NSRH_ASSERT_IMPL(a_full_no_hit, out_valid_o && store_full_o, !hit_found_o)
  `NSRH_ASSERT_IMPL(a_miss_zero, out_valid_o && !hit_found_o, (hit_x_o == 32'sd0) && (hit_y_o == 32'sd0) && (hit_index_o == 6'd0))

endmodule
`default_nettype wire

FILE: src/nsrh_datapath.sv
// Datapath: segment store, shared multiplier, serial divider and best-hit registers.
`timescale 1ns / 1ps
`default_nettype none
module nsrh_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic signed [31:0]   start_x_i,
  input  wire logic signed [31:0]   start_y_i,
  input  wire logic signed [31:0]   end_x_i,
  input  wire logic signed [31:0]   end_y_i,
  input  wire nsrh_pkg::dp_cmd_t    cmd_i,
  output nsrh_pkg::dp_status_t      status_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic                      hit_found_o,
  output logic signed [31:0]        hit_x_o,
  output logic signed [31:0]        hit_y_o,
  output logic [5:0]                hit_index_o,
  output logic                      store_full_o
);
  import nsrh_pkg::*;

  logic [SegW-1:0] mem [MaxSegments];
  logic [SegW-1:0] rdata_q;

  logic [CntW-1:0]    count_q;
  logic [IdxW-1:0]    k_q;
  logic [DivCntW-1:0] divcnt_q;
  logic               out_valid_q;

  logic signed [CoordW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [CoordW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [DiffW-1:0]  rx_q, ry_q, qx_q, qy_q, dx_q, dy_q;
  logic signed [MulPW-1:0]  acc_q, dist_q, best_q;
  logic signed [CrossW-1:0] den_q, num_q;
  logic signed [ProdW-1:0]  prod_q, quot_q, px_q, py_q;
  logic [CrossW-1:0]        dmag_q;
  logic [RemW-1:0]          rem_q;
  logic [ProdW-1:0]         dq_q;
  logic                     neg_q;
  logic                     found_q, full_q;
  logic signed [CoordW-1:0] bestx_q, besty_q;
  logic [IdxW-1:0]          bidx_q;
  logic                     res_found_q, res_full_q;
  logic signed [CoordW-1:0] res_x_q, res_y_q;
  logic [IdxW-1:0]          res_idx_q;

  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [MulPW-1:0]  mul_p;
  logic signed [DiffW-1:0]  asx, asy;
  logic [RemW-1:0]          rem_sh;
  logic                     rem_ge;
  logic                     is_full;

  function automatic logic in_rng(input logic signed [ProdW-1:0] p,
                                  input logic signed [CoordW-1:0] a,
                                  input logic signed [CoordW-1:0] b);
    logic signed [ProdW-1:0] ea, eb;
    ea = ProdW'(a);
    eb = ProdW'(b);
    return ((p >= ea) && (p <= eb)) || ((p >= eb) && (p <= ea));
  endfunction

  assign is_full = (count_q == CntW'(MaxSegments));
  assign asx     = DiffW'(ax_q) - DiffW'(sx_q);
  assign asy     = DiffW'(ay_q) - DiffW'(sy_q);
  assign rem_sh  = {rem_q[RemW-2:0], dq_q[ProdW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dmag_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      DP_DEN0: begin mul_a = MulW'(rx_q); mul_b = MulW'(qy_q); end
      DP_DEN1: begin mul_a = MulW'(ry_q); mul_b = MulW'(qx_q); end
      DP_NUM0: begin mul_a = MulW'(asx);  mul_b = MulW'(ry_q); end
      DP_NUM1: begin mul_a = MulW'(asy);  mul_b = MulW'(rx_q); end
      DP_PX0: begin
        mul_a = MulW'(qx_q);
        mul_b = MulW'({1'b0, num_q[NumSplit-1:0]});
      end
      DP_PX1: begin
        mul_a = MulW'(qx_q);
        mul_b = MulW'($signed(num_q[CrossW-1:NumSplit]));
      end
      DP_PY0: begin
        mul_a = MulW'(qy_q);
        mul_b = MulW'({1'b0, num_q[NumSplit-1:0]});
      end
      DP_PY1: begin
        mul_a = MulW'(qy_q);
        mul_b = MulW'($signed(num_q[CrossW-1:NumSplit]));
      end
      DP_DIST0: begin mul_a = MulW'(dx_q); mul_b = MulW'(dx_q); end
      DP_DIST1: begin mul_a = MulW'(dy_q); mul_b = MulW'(dy_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == DP_APPEND) && !is_full) begin
      mem[count_q[IdxW-1:0]] <= {sx_q, sy_q, ex_q, ey_q};
    end
    if (cmd_i.op == DP_READ) begin
      rdata_q <= mem[k_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      k_q         <= '0;
      divcnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        DP_CLEAR:   count_q <= '0;
        DP_APPEND:  if (!is_full) count_q <= count_q + CntW'(1);
        DP_RAYINIT: k_q <= '0;
        DP_NEXT:    k_q <= k_q + IdxW'(1);
        DP_DIVLD:   divcnt_q <= DivCntW'(DivSteps);
        DP_DIVSTEP: divcnt_q <= divcnt_q - DivCntW'(1);
        default: ;
      endcase
      if (cmd_i.op == DP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LATCH: begin
        sx_q    <= start_x_i;
        sy_q    <= start_y_i;
        ex_q    <= end_x_i;
        ey_q    <= end_y_i;
        found_q <= 1'b0;
        full_q  <= 1'b0;
        bestx_q <= '0;
        besty_q <= '0;
        bidx_q  <= '0;
      end
      DP_APPEND: full_q <= is_full;
      DP_RAYINIT: begin
        rx_q <= DiffW'(ex_q) - DiffW'(sx_q);
        ry_q <= DiffW'(ey_q) - DiffW'(sy_q);
      end
      DP_LOAD: begin
        ax_q <= $signed(rdata_q[4*CoordW-1:3*CoordW]);
        ay_q <= $signed(rdata_q[3*CoordW-1:2*CoordW]);
        bx_q <= $signed(rdata_q[2*CoordW-1:CoordW]);
        by_q <= $signed(rdata_q[CoordW-1:0]);
        qx_q <= DiffW'($signed(rdata_q[2*CoordW-1:CoordW]))
              - DiffW'($signed(rdata_q[4*CoordW-1:3*CoordW]));
        qy_q <= DiffW'($signed(rdata_q[CoordW-1:0]))
              - DiffW'($signed(rdata_q[3*CoordW-1:2*CoordW]));
      end
      DP_DEN0, DP_NUM0, DP_PX0, DP_PY0, DP_DIST0: acc_q <= mul_p;
      DP_DEN1: den_q <= CrossW'(acc_q - mul_p);
      DP_NUM1: num_q <= CrossW'(acc_q - mul_p);
      DP_PX1, DP_PY1: prod_q <= ProdW'(acc_q) + (ProdW'(mul_p) <<< NumSplit);
      DP_DIVLD: begin
        neg_q  <= prod_q[ProdW-1] ^ den_q[CrossW-1];
        dq_q   <= prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
        dmag_q <= den_q[CrossW-1] ? CrossW'(-den_q) : CrossW'(den_q);
        rem_q  <= '0;
      end
      DP_DIVSTEP: begin
        if (rem_ge) begin
          rem_q <= rem_sh - {1'b0, dmag_q};
          dq_q  <= {dq_q[ProdW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          dq_q  <= {dq_q[ProdW-2:0], 1'b0};
        end
      end
      DP_FIXQ: begin
        if (!neg_q) begin
          quot_q <= $signed(dq_q);
        end else if (rem_q != '0) begin
          quot_q <= $signed(~dq_q);
        end else begin
          quot_q <= $signed(-dq_q);
        end
      end
      DP_SETX: px_q <= ProdW'(ax_q) + quot_q;
      DP_SETY: py_q <= ProdW'(ay_q) + quot_q;
      DP_CHECK: begin
        dx_q <= DiffW'($signed(px_q[CoordW-1:0])) - DiffW'(sx_q);
        dy_q <= DiffW'($signed(py_q[CoordW-1:0])) - DiffW'(sy_q);
      end
      DP_DIST1: dist_q <= acc_q + mul_p;
      DP_UPDATE: begin
        if (status_o.closer) begin
          found_q <= 1'b1;
          best_q  <= dist_q;
          bestx_q <= $signed(px_q[CoordW-1:0]);
          besty_q <= $signed(py_q[CoordW-1:0]);
          bidx_q  <= k_q;
        end
      end
      DP_EMIT: begin
        res_found_q <= found_q;
        res_x_q     <= bestx_q;
        res_y_q     <= besty_q;
        res_idx_q   <= bidx_q;
        res_full_q  <= full_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.store_empty = (count_q == '0);
    status_o.den_zero    = (den_q == '0);
    status_o.div_last    = (divcnt_q == DivCntW'(1));
    status_o.hit_ok      = in_rng(px_q, sx_q, ex_q) && in_rng(py_q, sy_q, ey_q)
                        && in_rng(px_q, ax_q, bx_q) && in_rng(py_q, ay_q, by_q)
                        && !((px_q == ProdW'(sx_q)) && (py_q == ProdW'(sy_q)));
    status_o.closer      = !found_q || (dist_q < best_q);
    status_o.scan_last   = ((CntW'(k_q) + CntW'(1)) == count_q);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign hit_found_o  = res_found_q;
  assign hit_x_o      = res_x_q;
  assign hit_y_o      = res_y_q;
  assign hit_index_o  = res_idx_q;
  assign store_full_o = res_full_q;

endmodule
`default_nettype wire

FILE: src/nsrh_ctrl.sv
// Controller: state machine that sequences the datapath for each item.
`timescale 1ns / 1ps
`default_nettype none
module nsrh_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic [1:0]           opcode_i,
  output logic                      in_ready_o,
  input  wire nsrh_pkg::dp_status_t status_i,
  output nsrh_pkg::dp_cmd_t         cmd_o
);
  import nsrh_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = DP_NOP;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (opcode_e'(opcode_i))
            OP_CLEAR:  cmd_o.op = DP_CLEAR;
            OP_APPEND: begin cmd_o.op = DP_LATCH; state_d = ST_APPEND;  end
            OP_CAST:   begin cmd_o.op = DP_LATCH; state_d = ST_RAYINIT; end
            default:   cmd_o.op = DP_NOP;
          endcase
        end
      end
      ST_APPEND: begin cmd_o.op = DP_APPEND; state_d = ST_EMIT; end
      ST_RAYINIT: begin
        cmd_o.op = DP_RAYINIT;
        state_d  = status_i.store_empty ? ST_EMIT : ST_READ;
      end
      ST_READ: begin cmd_o.op = DP_READ; state_d = ST_LOAD; end
      ST_LOAD: begin cmd_o.op = DP_LOAD; state_d = ST_DEN0; end
      ST_DEN0: begin cmd_o.op = DP_DEN0; state_d = ST_DEN1; end
      ST_DEN1: begin cmd_o.op = DP_DEN1; state_d = ST_NUM0; end
      ST_NUM0: begin
        if (status_i.den_zero) begin
          state_d = ST_NEXT;
        end else begin
          cmd_o.op = DP_NUM0;
          state_d  = ST_NUM1;
        end
      end
      ST_NUM1: begin cmd_o.op = DP_NUM1; state_d = ST_PX0; end
      ST_PX0:  begin cmd_o.op = DP_PX0;  state_d = ST_PX1; end
      ST_PX1:  begin cmd_o.op = DP_PX1;  state_d = ST_DLDX; end
      ST_DLDX: begin cmd_o.op = DP_DIVLD; state_d = ST_DIVX; end
      ST_DIVX: begin
        cmd_o.op = DP_DIVSTEP;
        if (status_i.div_last) state_d = ST_FIXX;
      end
      ST_FIXX: begin cmd_o.op = DP_FIXQ; state_d = ST_SETX; end
      ST_SETX: begin cmd_o.op = DP_SETX; state_d = ST_PY0; end
      ST_PY0:  begin cmd_o.op = DP_PY0;  state_d = ST_PY1; end
      ST_PY1:  begin cmd_o.op = DP_PY1;  state_d = ST_DLDY; end
      ST_DLDY: begin cmd_o.op = DP_DIVLD; state_d = ST_DIVY; end
      ST_DIVY: begin
        cmd_o.op = DP_DIVSTEP;
        if (status_i.div_last) state_d = ST_FIXY;
      end
      ST_FIXY: begin cmd_o.op = DP_FIXQ; state_d = ST_SETY; end
      ST_SETY: begin cmd_o.op = DP_SETY; state_d = ST_CHECK; end
      ST_CHECK: begin
        cmd_o.op = DP_CHECK;
        state_d  = status_i.hit_ok ? ST_DIST0 : ST_NEXT;
      end
      ST_DIST0:  begin cmd_o.op = DP_DIST0;  state_d = ST_DIST1; end
      ST_DIST1:  begin cmd_o.op = DP_DIST1;  state_d = ST_UPDATE; end
      ST_UPDATE: begin cmd_o.op = DP_UPDATE; state_d = ST_NEXT; end
      ST_NEXT: begin
        cmd_o.op = DP_NEXT;
        state_d  = status_i.scan_last ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = DP_EMIT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: tb/nearest_segment_ray_hit_checker.sv
// Checker for the nearest segment ray hit block: predicts and compares each result.
`timescale 1ns / 1ps
module nearest_segment_ray_hit_checker
  import nsrh_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic signed [31:0] end_x_i,
  input  logic signed [31:0] end_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               hit_found_i,
  input  logic signed [31:0] hit_x_i,
  input  logic signed [31:0] hit_y_i,
  input  logic [5:0]         hit_index_i,
  input  logic               store_full_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 hits_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [5:0]         idx;
    logic               full;
  } hit_result_t;

  logic signed [31:0] seg_ax[MaxSegments];
  logic signed [31:0] seg_ay[MaxSegments];
  logic signed [31:0] seg_bx[MaxSegments];
  logic signed [31:0] seg_by[MaxSegments];
  int                 seg_count;
  hit_result_t        expected_hits[$];

  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    wide_t r;
    q = n / d;
    r = n % d;
    if (r != 0 && ((n < 0) != (d < 0))) q = q - 1;
    return q;
  endfunction

  function automatic bit in_span(wide_t p, wide_t a, wide_t b);
    wide_t lo;
    wide_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return p >= lo && p <= hi;
  endfunction

  function automatic hit_result_t nearest_hit(wide_t sx, wide_t sy, wide_t ex, wide_t ey);
    hit_result_t res;
    wide_t rx, ry, ax, ay, bx, by, qx, qy, den, num, px, py, dx, dy, sq_dist, best;
    bit found;
    res = '{hit: 1'b0, x: '0, y: '0, idx: '0, full: 1'b0};
    found = 0;
    best = 0;
    rx = ex - sx;
    ry = ey - sy;
    for (int k = 0; k < seg_count; k++) begin
      ax = seg_ax[k];
      ay = seg_ay[k];
      bx = seg_bx[k];
      by = seg_by[k];
      qx = bx - ax;
      qy = by - ay;
      den = rx * qy - ry * qx;
      if (den == 0) continue;
      num = (ax - sx) * ry - (ay - sy) * rx;
      px = ax + floor_div(qx * num, den);
      py = ay + floor_div(qy * num, den);
      if (!in_span(px, sx, ex) || !in_span(py, sy, ey) ||
          !in_span(px, ax, bx) || !in_span(py, ay, by)) continue;
      if (px == sx && py == sy) continue;
      dx = px - sx;
      dy = py - sy;
      sq_dist = dx * dx + dy * dy;
      if (!found || sq_dist < best) begin
        found = 1;
        best = sq_dist;
        res.hit = 1'b1;
        res.x = px[31:0];
        res.y = py[31:0];
        res.idx = k[5:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t checker: %s mismatch, got %h want %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    hits_o = 0;
    pending_o = 0;
    seg_count = 0;
  end

  always @(posedge clk_i) begin
    hit_result_t res;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        res = '{hit: 1'b0, x: '0, y: '0, idx: '0, full: 1'b0};
        case (opcode_e'(opcode_i))
          OP_CLEAR: seg_count = 0;
          OP_APPEND: begin
            if (seg_count >= MaxSegments) begin
              res.full = 1'b1;
            end else begin
              seg_ax[seg_count] = start_x_i;
              seg_ay[seg_count] = start_y_i;
              seg_bx[seg_count] = end_x_i;
              seg_by[seg_count] = end_y_i;
              seg_count++;
            end
            expected_hits.insert(expected_hits.size(), res);
          end
          OP_CAST: begin
            res = nearest_hit(start_x_i, start_y_i, end_x_i, end_y_i);
            if (res.hit) hits_o++;
            expected_hits.insert(expected_hits.size(), res);
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_hits.size() == 0) begin
          $display("%0t checker: result with no item pending", $realtime);
          fail_count_o++;
        end else begin
          res = expected_hits.pop_front();
          if (hit_found_i !== res.hit) report_mismatch("hit_found", hit_found_i, res.hit);
          if (hit_x_i !== res.x) report_mismatch("hit_x", hit_x_i, res.x);
          if (hit_y_i !== res.y) report_mismatch("hit_y", hit_y_i, res.y);
          if (hit_index_i !== res.idx) report_mismatch("hit_index", hit_index_i, res.idx);
          if (store_full_i !== res.full) report_mismatch("store_full", store_full_i, res.full);
        end
      end
    end
    pending_o = expected_hits.size();
  end

endmodule

FILE: tb/tb_nearest_segment_ray_hit_top.sv
// Testbench top for the nearest segment ray hit block: stimulus and verdict.
`timescale 1ns / 1ps
module tb_nearest_segment_ray_hit_top;
  import nsrh_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic signed [31:0] start_x, start_y, end_x, end_y;
  logic               out_valid;
  logic               out_ready;
  logic               hit_found;
  logic signed [31:0] hit_x, hit_y;
  logic [5:0]         hit_index;
  logic               store_full;
  int                 fail_count;
  int                 pending;
  int                 hits;

  bit quiet;
  bit long_hold;
  int items_sent;
  int casts_sent;
  int appends_sent;
  int ray_sx, ray_sy, ray_ex, ray_ey;

  nearest_segment_ray_hit_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode),
    .start_x_i   (start_x),
    .start_y_i   (start_y),
    .end_x_i     (end_x),
    .end_y_i     (end_y),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .hit_found_o (hit_found),
    .hit_x_o     (hit_x),
    .hit_y_o     (hit_y),
    .hit_index_o (hit_index),
    .store_full_o(store_full)
  );

  nearest_segment_ray_hit_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .opcode_i    (opcode),
    .start_x_i   (start_x),
    .start_y_i   (start_y),
    .end_x_i     (end_x),
    .end_y_i     (end_y),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .hit_found_i (hit_found),
    .hit_x_i     (hit_x),
    .hit_y_i     (hit_y),
    .hit_index_i (hit_index),
    .store_full_i(store_full),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .hits_o      (hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("tb_nearest_segment_ray_hit_top: done, errors");
    $finish;
  end

  function automatic int near_coord();
    return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
  endfunction

  task automatic push_item(opcode_e op, int sx, int sy, int ex, int ey);
    in_valid <= 1'b1;
    opcode   <= op;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
    if (op == OP_CAST) casts_sent++;
    if (op == OP_APPEND) appends_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic pick_ray();
    ray_sx = near_coord();
    ray_sy = near_coord();
    ray_ex = near_coord();
    ray_ey = near_coord();
  endtask

  // Segment across the ray at a random fraction of its length, or at times one lying along the ray from that point.
  task automatic append_crossing();
    int t, mx, my, dx, dy;
    t  = $urandom_range(0, 8);
    mx = ray_sx + (ray_ex - ray_sx) * t / 8;
    my = ray_sy + (ray_ey - ray_sy) * t / 8;
    dx = int'($urandom_range(0, 2 ** 19)) - 2 ** 18;
    dy = int'($urandom_range(0, 2 ** 19)) - 2 ** 18;
    if ($urandom_range(0, 5) == 0)
      push_item(OP_APPEND, mx, my, mx + (ray_ex - ray_sx) / 4, my + (ray_ey - ray_sy) / 4);
    else
      push_item(OP_APPEND, mx - dx, my - dy, mx + dx, my + dy);
  endtask

  initial begin
    bit held, drained;
    int n;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    opcode = OP_NONE;
    start_x = '0;
    start_y = '0;
    end_x = '0;
    end_y = '0;
    quiet = 0;
    long_hold = 0;
    held = 0;
    drained = 0;
    items_sent = 0;
    casts_sent = 0;
    appends_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_item(OP_CAST, 0, 0, 65536, 65536);
    push_item(OP_APPEND, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    push_item(OP_APPEND, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    push_item(OP_CAST, 32'sh80000000, 0, 32'sh7fffffff, 0);
    push_item(OP_CAST, 0, 32'sh7fffffff, 0, 32'sh80000000);
    push_item(OP_CAST, 5, 5, 5, 5);
    push_item(OP_NONE, -1, -1, -1, -1);
    push_item(OP_CLEAR, 0, 0, 0, 0);
    push_item(OP_APPEND, 0, 65536, 65536 * 4, 65536);
    push_item(OP_CAST, 0, 0, 65536 * 4, 0);
    push_item(OP_APPEND, 65536, 0, 65536, 65536 * 4);
    push_item(OP_APPEND, 65536, 0, 65536, 65536 * 4);
    push_item(OP_APPEND, 3, 3, 3, 3);
    push_item(OP_CAST, 0, 65536, 65536 * 4, 65536);
    push_item(OP_CAST, 65536, 65536, 65536 * 8, 65536 * 8);
    push_item(OP_CAST, 65536, 65536, -65536 * 8, 65536 * 8);
    push_item(OP_APPEND, 7, -9, 7, 11);
    push_item(OP_CAST, 0, 0, 14, 1);
    push_item(OP_CAST, 0, 0, 14, 0);
    push_item(OP_CLEAR, 0, 0, 0, 0);
    push_item(OP_CAST, 0, 0, 14, 0);

    while (items_sent < 1250) begin
      n = $urandom_range(0, 99);
      if (!held && items_sent > 400) begin
        held = 1;
        long_hold = 1;
      end
      if (!drained && items_sent > 700) begin
        drained = 1;
        in_valid <= 1'b0;
        @(posedge clk_i);
        wait (pending == 0);
        repeat (20) @(posedge clk_i);
      end
      if (items_sent > 1100) quiet = 1;
      if (n < 2) begin
        pick_ray();
        push_item(OP_CLEAR, 0, 0, 0, 0);
        repeat (MaxSegments + 2) append_crossing();
        push_item(OP_CAST, ray_sx, ray_sy, ray_ex, ray_ey);
        push_item(OP_CAST, ray_ex, ray_ey, ray_sx, ray_sy);
        push_item(OP_CLEAR, 0, 0, 0, 0);
      end else if (n < 10) begin
        repeat ($urandom_range(1, 4))
          push_item(opcode_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
      end else begin
        pick_ray();
        push_item(OP_CLEAR, 0, 0, 0, 0);
        repeat ($urandom_range(1, 4)) append_crossing();
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 3))
            0: push_item(OP_CAST, ray_ex, ray_ey, ray_sx, ray_sy);
            1: push_item(OP_CAST, ray_sx, ray_sy, near_coord(), near_coord());
            default: push_item(OP_CAST, ray_sx, ray_sy, ray_ex, ray_ey);
          endcase
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d items: %0d appends, %0d casts, %0d casts with a hit.",
             items_sent, appends_sent, casts_sent, hits);
    if (fail_count == 0) begin
      $display("tb_nearest_segment_ray_hit_top: done, clean");
    end else begin
      $display("tb_nearest_segment_ray_hit_top: done, errors");
    end
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

endmodule
